// ----- src/awir_pkg.sv -----
// Shared constants and codes for the alpha-weighted image resampler.
// No dependencies; compiled first.
package awir_pkg;

    localparam int OPC_W      = 1;
    localparam int COORD_W    = 8;
    localparam int PIX_W      = 32;
    localparam int OUT_XY_W   = 12;
    localparam int CHAN_W     = 8;
    localparam int SRC_SIZE_W = 9;
    localparam int DST_SIZE_W = 13;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [OPC_W-1:0] OPC_STORE  = 1'b0;
    localparam logic [OPC_W-1:0] OPC_SAMPLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER     = 3'd4;

    localparam logic [MODE_W-1:0] MODE_NEAREST  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BILINEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BICUBIC  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_INVALID  = 2'd3;

    localparam logic [SRC_SIZE_W-1:0] RST_SRC_SIZE = 9'd256;
    localparam logic [DST_SIZE_W-1:0] RST_DST_SIZE = 13'd256;

endpackage

// ----- src/awir_if.sv -----
// Request and result channel interfaces (valid/ready) for the resampler.
// Depends on awir_pkg.
interface awir_sample_if
    import awir_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [OPC_W-1:0]      opcode;
    logic [COORD_W-1:0]    write_x;
    logic [COORD_W-1:0]    write_y;
    logic [PIX_W-1:0]      write_pixel;
    logic [OUT_XY_W-1:0]   out_x;
    logic [OUT_XY_W-1:0]   out_y;

    modport source (output valid, opcode, write_x, write_y, write_pixel, out_x, out_y,
                    input ready);
    modport sink   (input valid, opcode, write_x, write_y, write_pixel, out_x, out_y,
                    output ready);
endinterface

interface awir_result_if
    import awir_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;

    modport source (output valid, red, green, blue, alpha, input ready);
    modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

// ----- src/awir_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by the resampler.
// Depends on awir_pkg (for house consistency only).
module awir_div
    import awir_pkg::*;
#(
    parameter int NUMW = 44,
    parameter int DENW = 29
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [NUMW-1:0] num,
    input  logic [DENW-1:0] den,
    output logic            busy,
    output logic            done,
    output logic [NUMW-1:0] quo
);
    localparam int CNTW = $clog2(NUMW + 1);

    logic [DENW-1:0] rem_reg, rem_next;
    logic [NUMW-1:0] quo_reg, quo_next;
    logic [DENW-1:0] den_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg, done_reg;
    logic [DENW:0]   trial;
    logic            qbit;

    always_comb
    begin
        trial = {rem_reg, quo_reg[NUMW-1]};
        qbit  = (trial >= {1'b0, den_reg});
        rem_next = qbit ? DENW'(trial - {1'b0, den_reg}) : DENW'(trial);
        quo_next = {quo_reg[NUMW-2:0], qbit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(NUMW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ----- src/alpha_weighted_image_resampler.sv -----
// Store item: written to memory if write_x/write_y are in range. Sample item:
// two divisions on the shared divider for coordinates, then taps read through
// the single memory read port, premultiplied and accumulated, rows weighted,
// then one division per color channel (skipped if alpha divisor or channel
// sum is not positive, and in nearest mode). One item at a time.
// Reset clears control and config registers; image memory is not cleared.
module alpha_weighted_image_resampler
    import awir_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    awir_sample_if.sink           sample,
    awir_result_if.source         result
);
    localparam int F     = FRAC_BITS;
    localparam int XA    = $clog2(MAX_WIDTH);
    localparam int YA    = $clog2(MAX_HEIGHT);
    localparam int DEPTH = 2 ** (XA + YA);
    localparam int MAXWH = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int EW    = $clog2(MAXWH + 1);
    localparam int SXW   = OUT_XY_W + EW + F;
    localparam int CXW   = OUT_XY_W + EW + 2;
    localparam int WTW   = F + 2;
    localparam int ROWW  = F + 20;
    localparam int ACW   = 2 * F + 24;
    localparam int NUMW  = 2 * F + 28;
    localparam int DENW  = 2 * F + 13;
    localparam int SAW   = 12;
    localparam int RW    = 3 * F + 4;

    localparam logic signed [RW-1:0]  TWO_S3   = RW'(1) << (3 * F + 1);
    localparam logic signed [RW-1:0]  RND      = RW'(1) << (2 * F);
    localparam logic signed [WTW-1:0] ONE_W    = WTW'(1) << F;
    localparam logic [SXW:0]          ONE_SX   = (SXW + 1)'(1) << F;
    localparam logic [SXW:0]          HALF_SX  = (SXW + 1)'(1) << (F - 1);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_SXD   = 14'b00000000000010,
        S_SXW   = 14'b00000000000100,
        S_SYD   = 14'b00000000001000,
        S_SYW   = 14'b00000000010000,
        S_PREP  = 14'b00000000100000,
        S_CUB   = 14'b00000001000000,
        S_ADDR  = 14'b00000010000000,
        S_PREM  = 14'b00000100000000,
        S_MAC   = 14'b00001000000000,
        S_ROW   = 14'b00010000000000,
        S_CDIV  = 14'b00100000000000,
        S_CWAIT = 14'b01000000000000,
        S_OUT   = 14'b10000000000000
    } state_t;

    state_t state_reg;

    logic [SRC_SIZE_W-1:0] src_w_reg, src_h_reg;
    logic [DST_SIZE_W-1:0] dst_w_reg, dst_h_reg;
    logic [MODE_W-1:0]     mode_reg;

    logic [OUT_XY_W-1:0]   ox_reg, oy_reg;
    logic [SXW-1:0]        sx_reg, sy_reg;
    logic [F-1:0]          fx_reg, fy_reg;
    logic signed [CXW-1:0] x0_reg, y0_reg;
    logic [1:0]            ti_reg, tj_reg, nlast_reg, chan_reg;
    logic [2:0]            wstep_reg;
    logic [2*F-1:0]        f2_reg;
    logic [3*F-1:0]        f3_reg;
    logic signed [WTW-1:0] wx_reg [4];
    logic signed [WTW-1:0] wy_reg [4];
    logic [31:0]           mem [0:DEPTH-1];
    logic [31:0]           rd_reg;
    logic [15:0]           pm_reg [4];
    logic [SAW-1:0]        sum_a_reg;
    logic signed [ROWW-1:0] row_reg [4];
    logic signed [ACW-1:0]  acc_reg [4];
    logic [CHAN_W-1:0]     col_reg [4];
    logic                  out_valid_reg;
    logic [CHAN_W-1:0]     out_r_reg, out_g_reg, out_b_reg, out_a_reg;

    // effective sizes
    logic [EW-1:0]         eff_w, eff_h;
    logic [DST_SIZE_W-1:0] dw, dh;

    always_comb
    begin
        if (src_w_reg == '0)
            eff_w = EW'(1);
        else if (32'(src_w_reg) > MAX_WIDTH)
            eff_w = EW'(MAX_WIDTH);
        else
            eff_w = EW'(src_w_reg);
        if (src_h_reg == '0)
            eff_h = EW'(1);
        else if (32'(src_h_reg) > MAX_HEIGHT)
            eff_h = EW'(MAX_HEIGHT);
        else
            eff_h = EW'(src_h_reg);
        dw = (dst_w_reg == '0) ? DST_SIZE_W'(1) : dst_w_reg;
        dh = (dst_h_reg == '0) ? DST_SIZE_W'(1) : dst_h_reg;
    end

    // handshake
    logic in_acc, store_ok;

    assign sample.ready = (state_reg == S_IDLE);
    assign in_acc   = sample.valid && sample.ready;
    assign store_ok = in_acc && (sample.opcode == OPC_STORE)
                   && (32'(sample.write_x) < MAX_WIDTH)
                   && (32'(sample.write_y) < MAX_HEIGHT);

    // shared divider
    logic            div_start, div_busy, div_done;
    logic [NUMW-1:0] div_num, div_quo;
    logic [DENW-1:0] div_den;
    logic [DENW-1:0] color_den;
    logic            cubic;

    assign cubic = (mode_reg == MODE_BICUBIC);

    always_comb
    begin
        if (cubic)
            color_den = DENW'({sum_a_reg, {(2 * F){1'b0}}});
        else
            color_den = DENW'({sum_a_reg[SAW-1:2], {(2 * F){1'b0}}});
    end

    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (state_reg)
            S_SXD:
            begin
                div_start = 1'b1;
                div_num   = NUMW'({(OUT_XY_W + EW)'(ox_reg) * (OUT_XY_W + EW)'(eff_w),
                                   {F{1'b0}}});
                div_den   = DENW'(dw);
            end
            S_SYD:
            begin
                div_start = 1'b1;
                div_num   = NUMW'({(OUT_XY_W + EW)'(oy_reg) * (OUT_XY_W + EW)'(eff_h),
                                   {F{1'b0}}});
                div_den   = DENW'(dh);
            end
            S_CDIV:
            begin
                div_start = (color_den != '0) && (acc_reg[chan_reg] > 0);
                if (cubic)
                    div_num = NUMW'({acc_reg[chan_reg][ACW-2:0], 4'b0000});
                else
                    div_num = NUMW'(acc_reg[chan_reg][ACW-2:0]);
                div_den = color_den;
            end
            default: ;
        endcase
    end

    awir_div #(.NUMW(NUMW), .DENW(DENW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    // positions
    logic [SXW:0]          xp, yp, xn, yn;
    logic signed [CXW-1:0] xi, yi;

    always_comb
    begin
        xp = (SXW + 1)'(sx_reg) + HALF_SX;
        yp = (SXW + 1)'(sy_reg) + HALF_SX;
        xn = (SXW + 1)'(sx_reg) + ONE_SX;
        yn = (SXW + 1)'(sy_reg) + ONE_SX;
        xi = $signed(CXW'(xp >> F));
        yi = $signed(CXW'(yp >> F));
    end

    // cubic weights: one multiplier shared over six steps
    logic [F-1:0]          f_sel;
    logic [2*F-1:0]        mul_a;
    logic [3*F-1:0]        mul_p;
    logic signed [RW-1:0]  f_e, f2_e, f3_e, f2s;
    logic signed [RW-1:0]  raw [4];
    logic signed [WTW-1:0] cw [4];

    always_comb
    begin
        f_sel = (wstep_reg < 3'd3) ? fx_reg : fy_reg;
        if (wstep_reg == 3'd1 || wstep_reg == 3'd4)
            mul_a = f2_reg;
        else
            mul_a = (2 * F)'(f_sel);
        mul_p = (3 * F)'(mul_a * f_sel);
        f_e  = $signed(RW'(f_sel));
        f2_e = $signed(RW'(f2_reg));
        f3_e = $signed(RW'(f3_reg));
        f2s  = f2_e <<< F;
        raw[0] = -(f_e <<< (2 * F)) + (f2_e <<< (F + 1)) - f3_e;
        raw[1] = TWO_S3 - ((f2s <<< 2) + f2s) + ((f3_e <<< 1) + f3_e);
        raw[2] = (f_e <<< (2 * F)) + (f2s <<< 2) - ((f3_e <<< 1) + f3_e);
        raw[3] = f3_e - f2s;
        for (int k = 0; k < 4; k++)
            cw[k] = WTW'((raw[k] + RND) >>> (2 * F + 1));
    end

    // tap address with edge clamp
    logic signed [CXW-1:0] tx, ty, cx, cy, ew_s, eh_s;
    logic [XA+YA-1:0]      rd_addr, wr_addr;

    always_comb
    begin
        tx   = x0_reg + $signed(CXW'(ti_reg));
        ty   = y0_reg + $signed(CXW'(tj_reg));
        ew_s = $signed(CXW'(eff_w));
        eh_s = $signed(CXW'(eff_h));
        if (tx < 0)
            cx = '0;
        else if (tx >= ew_s)
            cx = ew_s - 1;
        else
            cx = tx;
        if (ty < 0)
            cy = '0;
        else if (ty >= eh_s)
            cy = eh_s - 1;
        else
            cy = ty;
        rd_addr = {YA'(cy), XA'(cx)};
        wr_addr = {YA'(sample.write_y), XA'(sample.write_x)};
    end

    always_ff @(posedge clk)
    begin
        if (store_ok)
            mem[wr_addr] <= sample.write_pixel;
        if (state_reg == S_ADDR)
            rd_reg <= mem[rd_addr];
    end

    // alpha result
    logic signed [ACW-1:0] a_shift;
    logic [CHAN_W-1:0]     a_sat;
    logic [7:0]            rd_a;

    always_comb
    begin
        a_shift = acc_reg[3] >>> (2 * F);
        if (acc_reg[3] <= 0)
            a_sat = '0;
        else if (a_shift > 255)
            a_sat = 8'hFF;
        else
            a_sat = CHAN_W'(a_shift);
        rd_a = rd_reg[7:0];
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= RST_SRC_SIZE;
            src_h_reg <= RST_SRC_SIZE;
            dst_w_reg <= RST_DST_SIZE;
            dst_h_reg <= RST_DST_SIZE;
            mode_reg  <= MODE_BILINEAR;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SRC_WIDTH:  src_w_reg <= SRC_SIZE_W'(cfg_data);
                REG_SRC_HEIGHT: src_h_reg <= SRC_SIZE_W'(cfg_data);
                REG_DST_WIDTH:  dst_w_reg <= cfg_data;
                REG_DST_HEIGHT: dst_h_reg <= cfg_data;
                REG_FILTER:     mode_reg  <= MODE_W'(cfg_data);
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (result.ready && out_valid_reg)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (in_acc && sample.opcode == OPC_SAMPLE)
                        state_reg <= (mode_reg == MODE_INVALID) ? S_OUT : S_SXD;
                S_SXD:  state_reg <= S_SXW;
                S_SXW:  if (div_done) state_reg <= S_SYD;
                S_SYD:  state_reg <= S_SYW;
                S_SYW:  if (div_done) state_reg <= S_PREP;
                S_PREP: state_reg <= cubic ? S_CUB : S_ADDR;
                S_CUB:  if (wstep_reg == 3'd5) state_reg <= S_ADDR;
                S_ADDR: state_reg <= S_PREM;
                S_PREM: state_reg <= (mode_reg == MODE_NEAREST) ? S_OUT : S_MAC;
                S_MAC:  state_reg <= (ti_reg == nlast_reg) ? S_ROW : S_ADDR;
                S_ROW:  state_reg <= (tj_reg == nlast_reg) ? S_CDIV : S_ADDR;
                S_CDIV:
                    if (div_start)
                        state_reg <= S_CWAIT;
                    else if (chan_reg == 2'd2)
                        state_reg <= S_OUT;
                S_CWAIT:
                    if (div_done && chan_reg == 2'd2)
                        state_reg <= S_OUT;
                    else if (div_done)
                        state_reg <= S_CDIV;
                S_OUT:
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                ox_reg <= sample.out_x;
                oy_reg <= sample.out_y;
                for (int k = 0; k < 4; k++)
                    col_reg[k] <= '0;
            end
            S_SXW: if (div_done) sx_reg <= SXW'(div_quo);
            S_SYW: if (div_done) sy_reg <= SXW'(div_quo);
            S_PREP:
            begin
                fx_reg    <= xp[F-1:0];
                fy_reg    <= yp[F-1:0];
                ti_reg    <= '0;
                tj_reg    <= '0;
                chan_reg  <= '0;
                wstep_reg <= '0;
                sum_a_reg <= '0;
                for (int k = 0; k < 4; k++)
                begin
                    row_reg[k] <= '0;
                    acc_reg[k] <= '0;
                end
                case (mode_reg)
                    MODE_NEAREST:
                    begin
                        x0_reg    <= $signed(CXW'(xn >> F));
                        y0_reg    <= $signed(CXW'(yn >> F));
                        nlast_reg <= 2'd0;
                    end
                    MODE_BILINEAR:
                    begin
                        x0_reg    <= xi;
                        y0_reg    <= yi;
                        nlast_reg <= 2'd1;
                        wx_reg[0] <= ONE_W - $signed(WTW'(xp[F-1:0]));
                        wx_reg[1] <= $signed(WTW'(xp[F-1:0]));
                        wy_reg[0] <= ONE_W - $signed(WTW'(yp[F-1:0]));
                        wy_reg[1] <= $signed(WTW'(yp[F-1:0]));
                    end
                    default:
                    begin
                        x0_reg    <= xi - 1;
                        y0_reg    <= yi - 1;
                        nlast_reg <= 2'd3;
                    end
                endcase
            end
            S_CUB:
            begin
                wstep_reg <= wstep_reg + 3'd1;
                case (wstep_reg)
                    3'd0, 3'd3: f2_reg <= (2 * F)'(mul_p);
                    3'd1, 3'd4: f3_reg <= mul_p;
                    3'd2: for (int k = 0; k < 4; k++) wx_reg[k] <= cw[k];
                    default: for (int k = 0; k < 4; k++) wy_reg[k] <= cw[k];
                endcase
            end
            S_PREM:
            begin
                pm_reg[0] <= rd_reg[31:24] * rd_a;
                pm_reg[1] <= rd_reg[23:16] * rd_a;
                pm_reg[2] <= rd_reg[15:8] * rd_a;
                pm_reg[3] <= 16'(rd_a);
                sum_a_reg <= sum_a_reg + SAW'(rd_a);
                if (rd_a != '0)
                begin
                    col_reg[0] <= rd_reg[31:24];
                    col_reg[1] <= rd_reg[23:16];
                    col_reg[2] <= rd_reg[15:8];
                end
                col_reg[3] <= rd_a;
            end
            S_MAC:
            begin
                for (int k = 0; k < 4; k++)
                    row_reg[k] <= row_reg[k] + wx_reg[ti_reg] * $signed({1'b0, pm_reg[k]});
                ti_reg <= (ti_reg == nlast_reg) ? 2'd0 : ti_reg + 2'd1;
            end
            S_ROW:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    acc_reg[k] <= acc_reg[k] + wy_reg[tj_reg] * row_reg[k];
                    row_reg[k] <= '0;
                end
                tj_reg <= tj_reg + 2'd1;
            end
            S_CDIV:
            begin
                col_reg[3] <= a_sat;
                if (!div_start)
                begin
                    col_reg[chan_reg] <= '0;
                    chan_reg <= chan_reg + 2'd1;
                end
            end
            S_CWAIT:
                if (div_done)
                begin
                    col_reg[chan_reg] <= (div_quo > NUMW'(255)) ? 8'hFF : div_quo[7:0];
                    chan_reg <= chan_reg + 2'd1;
                end
            S_OUT:
                if (!out_valid_reg)
                begin
                    out_r_reg <= col_reg[0];
                    out_g_reg <= col_reg[1];
                    out_b_reg <= col_reg[2];
                    out_a_reg <= col_reg[3];
                end
            default: ;
        endcase
    end

    assign result.valid = out_valid_reg;
    assign result.red   = out_r_reg;
    assign result.green = out_g_reg;
    assign result.blue  = out_b_reg;
    assign result.alpha = out_a_reg;

`ifndef ASSERT_OFF
    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside output state");
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");
    a_ready_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        sample.ready |-> !div_busy)
        else $error("request taken with divider busy");
`endif

endmodule
